@@ rtl/batf_pkg.sv @@
// ----------------------------------------------------------------------------
// batf_pkg
// Shared types and constants for the read/update command to tag frame encoder.
// ----------------------------------------------------------------------------
package batf_pkg;

  localparam int UID_MAX_BYTES = 10;
  localparam int UID_BITS      = 8 * UID_MAX_BYTES;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_P1P2    = 2'd2;
  localparam logic [1:0] ST_LENGTH  = 2'd3;

  // opcode slots in the opcode table register
  localparam logic [2:0] OP_READALL = 3'd0;
  localparam logic [2:0] OP_READID  = 3'd1;
  localparam logic [2:0] OP_READ    = 3'd2;
  localparam logic [2:0] OP_READ8   = 3'd3;
  localparam logic [2:0] OP_RSEG    = 3'd4;
  localparam logic [2:0] OP_WRITEE  = 3'd5;
  localparam logic [2:0] OP_WRITEE8 = 3'd6;

  // length byte codes
  localparam logic [7:0] LEN_ALL  = 8'h00;
  localparam logic [7:0] LEN_ONE  = 8'h01;
  localparam logic [7:0] LEN_ID   = 8'h06;
  localparam logic [7:0] LEN_EGHT = 8'h08;
  localparam logic [7:0] LEN_SEG  = 8'h80;

  // parameter range limits
  localparam logic [7:0] P1_BLOCK_MAX = 8'h0f;
  localparam logic [7:0] P2_BYTE_MAX  = 8'h07;
  localparam logic [7:0] P2_SEG_MAX   = 8'h03;

  // command codes
  localparam logic CMD_READ   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_UID_LOW  = 3'd0;
  localparam logic [2:0] REG_UID_HIGH = 3'd1;
  localparam logic [2:0] REG_UID_LEN  = 3'd2;
  localparam logic [2:0] REG_MIN_HDR  = 3'd3;
  localparam logic [2:0] REG_OPCODES  = 3'd4;

  // classified request handed from the front to the back
  typedef struct packed {
    logic        err;
    logic [1:0]  status;
    logic [7:0]  opcode;
    logic [7:0]  addr;
    logic        body_data;
    logic [3:0]  nbody;
    logic [3:0]  nuid;
    logic [4:0]  total;
    logic [63:0] data;
  } frame_desc_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_t;

endpackage

@@ rtl/batf_front.sv @@
// ----------------------------------------------------------------------------
// batf_front
// Checks one command header and reduces it to a frame descriptor.
// ----------------------------------------------------------------------------
module batf_front (
  input  logic                  in_cmd,
  input  logic [7:0]            in_p1,
  input  logic [7:0]            in_p2,
  input  logic [7:0]            in_len_byte,
  input  logic [63:0]           in_data_bytes,
  input  logic [8:0]            in_apdu_length,
  input  logic [7:0]            in_out_capacity,
  input  logic [3:0]            uid_length,
  input  logic [3:0]            min_header_length,
  input  logic [55:0]           opcode_table,
  output batf_pkg::frame_desc_t desc
);

  logic       known;
  logic       ok;
  logic [2:0] op_sel;
  logic [3:0] nbody;
  logic       body_data;
  logic       with_uid;
  logic [7:0] addr;
  logic [3:0] ulen;
  logic [3:0] nuid;
  logic [4:0] total;

  always_comb begin
    known     = 1'b1;
    ok        = 1'b0;
    op_sel    = batf_pkg::OP_READALL;
    nbody     = 4'd1;
    body_data = 1'b0;
    with_uid  = 1'b1;
    addr      = 8'h00;
    if (in_cmd == batf_pkg::CMD_READ) begin
      case (in_len_byte)
        batf_pkg::LEN_ALL: begin
          ok     = (in_p1 == 8'h00) && (in_p2 == 8'h00);
          op_sel = batf_pkg::OP_READALL;
        end
        batf_pkg::LEN_ID: begin
          // opcode then six zeros, the address slot counts as the first zero
          ok       = (in_p1 == 8'h00) && (in_p2 == 8'h00);
          op_sel   = batf_pkg::OP_READID;
          nbody    = 4'd5;
          with_uid = 1'b0;
        end
        batf_pkg::LEN_ONE: begin
          ok     = (in_p1 <= batf_pkg::P1_BLOCK_MAX) && (in_p2 <= batf_pkg::P2_BYTE_MAX);
          op_sel = batf_pkg::OP_READ;
          addr   = {in_p1[4:0], 3'b000} | in_p2;
        end
        batf_pkg::LEN_EGHT: begin
          ok     = (in_p2 == 8'h00);
          op_sel = batf_pkg::OP_READ8;
          addr   = in_p1;
          nbody  = 4'd8;
        end
        batf_pkg::LEN_SEG: begin
          ok     = (in_p1 == 8'h00) && (in_p2 <= batf_pkg::P2_SEG_MAX);
          op_sel = batf_pkg::OP_RSEG;
          addr   = {in_p2[3:0], 4'b0000};
          nbody  = 4'd8;
        end
        default: begin
          known = 1'b0;
        end
      endcase
    end else begin
      case (in_len_byte)
        batf_pkg::LEN_ONE: begin
          ok        = (in_p1 <= batf_pkg::P1_BLOCK_MAX) && (in_p2 <= batf_pkg::P2_BYTE_MAX);
          op_sel    = batf_pkg::OP_WRITEE;
          addr      = {in_p1[4:0], 3'b000} | in_p2;
          body_data = 1'b1;
        end
        batf_pkg::LEN_EGHT: begin
          ok        = (in_p2 == 8'h00);
          op_sel    = batf_pkg::OP_WRITEE8;
          addr      = in_p1;
          nbody     = 4'd8;
          body_data = 1'b1;
        end
        default: begin
          known = 1'b0;
        end
      endcase
    end
  end

  assign ulen  = (uid_length > 4'(batf_pkg::UID_MAX_BYTES)) ?
                 4'(batf_pkg::UID_MAX_BYTES) : uid_length;
  assign nuid  = with_uid ? ulen : 4'd0;
  assign total = 5'd2 + {1'b0, nbody} + {1'b0, nuid};

  always_comb begin
    desc           = '0;
    desc.opcode    = opcode_table[{op_sel, 3'b000} +: 8];
    desc.addr      = addr;
    desc.body_data = body_data;
    desc.nbody     = nbody;
    desc.nuid      = nuid;
    desc.total     = total;
    desc.data      = in_data_bytes;
    desc.status    = batf_pkg::ST_OK;
    // checks in priority order, first failure wins
    if (in_apdu_length < {5'd0, min_header_length}) begin
      desc.err    = 1'b1;
      desc.status = batf_pkg::ST_INVALID;
    end else if (!known) begin
      desc.err    = 1'b1;
      desc.status = batf_pkg::ST_LENGTH;
    end else if (!ok) begin
      desc.err    = 1'b1;
      desc.status = batf_pkg::ST_P1P2;
    end else if (in_out_capacity < {3'd0, total}) begin
      desc.err    = 1'b1;
      desc.status = batf_pkg::ST_INVALID;
    end
  end

endmodule

@@ rtl/batf_fifo.sv @@
// ----------------------------------------------------------------------------
// batf_fifo
// Two-entry request queue between the header checker and the frame sequencer.
// ----------------------------------------------------------------------------
module batf_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  batf_pkg::frame_desc_t push_desc,
  input  logic                  pop,
  output batf_pkg::frame_desc_t pop_desc,
  output logic                  full,
  output logic                  empty
);

  batf_pkg::frame_desc_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_desc = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

@@ rtl/batf_back.sv @@
// ----------------------------------------------------------------------------
// batf_back
// Frame sequencer: walks one descriptor and sends the frame a byte per cycle.
// ----------------------------------------------------------------------------
module batf_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  batf_pkg::frame_desc_t         q_desc,
  output logic                          q_pop,
  input  logic [batf_pkg::UID_BITS-1:0] uid,
  output logic                          out_strobe,
  output logic [7:0]                    out_byte,
  output logic                          out_byte_valid,
  output logic                          out_last,
  output logic [1:0]                    out_status
);

  batf_pkg::back_state_t state_r, state_nxt;
  batf_pkg::frame_desc_t cur_r, cur_nxt;
  logic [4:0]   idx_r, idx_nxt;
  logic         strobe_r, strobe_nxt;
  logic [7:0]   byte_r, byte_nxt;
  logic         valid_r, valid_nxt;
  logic         last_r, last_nxt;
  logic [1:0]   status_r, status_nxt;

  logic [4:0]   rel;
  logic [4:0]   uidx;
  logic [127:0] uid_ext;
  logic [7:0]   frame_byte;
  logic         at_end;

  assign uid_ext = {(128 - batf_pkg::UID_BITS)'(0), uid};
  assign rel     = idx_r - 5'd2;
  assign uidx    = rel - {1'b0, cur_r.nbody};
  assign at_end  = (idx_r == cur_r.total - 5'd1);

  always_comb begin
    if (idx_r == 5'd0) begin
      frame_byte = cur_r.opcode;
    end else if (idx_r == 5'd1) begin
      frame_byte = cur_r.addr;
    end else if (rel < {1'b0, cur_r.nbody}) begin
      frame_byte = cur_r.body_data ? cur_r.data[{rel[2:0], 3'b000} +: 8] : 8'h00;
    end else begin
      frame_byte = uid_ext[{uidx[3:0], 3'b000} +: 8];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    idx_nxt    = idx_r;
    q_pop      = 1'b0;
    strobe_nxt = 1'b0;
    byte_nxt   = byte_r;
    valid_nxt  = valid_r;
    last_nxt   = last_r;
    status_nxt = status_r;
    case (state_r)
      batf_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cur_nxt   = q_desc;
          idx_nxt   = 5'd0;
          state_nxt = batf_pkg::BK_EMIT;
        end
      end
      batf_pkg::BK_EMIT: begin
        strobe_nxt = 1'b1;
        status_nxt = cur_r.status;
        if (cur_r.err) begin
          byte_nxt  = 8'h00;
          valid_nxt = 1'b0;
          last_nxt  = 1'b1;
          state_nxt = batf_pkg::BK_IDLE;
        end else begin
          byte_nxt  = frame_byte;
          valid_nxt = 1'b1;
          last_nxt  = at_end;
          idx_nxt   = idx_r + 5'd1;
          if (at_end) begin
            state_nxt = batf_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = batf_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= batf_pkg::BK_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    idx_r    <= idx_nxt;
    byte_r   <= byte_nxt;
    valid_r  <= valid_nxt;
    last_r   <= last_nxt;
    status_r <= status_nxt;
  end

  assign out_strobe     = strobe_r;
  assign out_byte       = byte_r;
  assign out_byte_valid = valid_r;
  assign out_last       = last_r;
  assign out_status     = status_r;

endmodule

@@ rtl/binary_apdu_to_tag_frame_unit.sv @@
// ----------------------------------------------------------------------------
// binary_apdu_to_tag_frame_unit
// Turns read-binary / update-binary command headers into tag command frames.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The header check
// runs in the accepting cycle and its descriptor enters a two-entry queue;
// busy is high only while that queue is full. The frame sequencer takes one
// descriptor per frame: it loads it in its idle state, then sends one
// result per cycle; a frame is 3 to 20 bytes, an error a single result.
// Results appear in the cycle after they are formed, each for a single
// cycle with out_strobe high; the receiver must take them as they come.
// Registers sit at byte address 8*i, 64 bits wide.
module binary_apdu_to_tag_frame_unit (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [7:0]  in_p1,
  input  logic [7:0]  in_p2,
  input  logic [7:0]  in_len_byte,
  input  logic [63:0] in_data_bytes,
  input  logic [8:0]  in_apdu_length,
  input  logic [7:0]  in_out_capacity,
  // result channel
  output logic        out_strobe,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_last,
  output logic [1:0]  out_status,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0] uid_low_r;
  logic [15:0] uid_high_r;
  logic [3:0]  uid_length_r;
  logic [3:0]  min_header_length_r;
  logic [55:0] opcode_table_r;

  logic [2:0]  reg_idx;
  logic        reg_wr;

  batf_pkg::frame_desc_t front_desc;
  batf_pkg::frame_desc_t q_desc;
  logic q_full, q_empty, q_pop, push;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uid_low_r           <= 64'd0;
      uid_high_r          <= 16'd0;
      uid_length_r        <= 4'd4;
      min_header_length_r <= 4'd5;
      opcode_table_r      <= 56'h54531002017800;
    end else if (reg_wr) begin
      case (reg_idx)
        batf_pkg::REG_UID_LOW:  uid_low_r           <= pwdata;
        batf_pkg::REG_UID_HIGH: uid_high_r          <= pwdata[15:0];
        batf_pkg::REG_UID_LEN:  uid_length_r        <= pwdata[3:0];
        batf_pkg::REG_MIN_HDR:  min_header_length_r <= pwdata[3:0];
        batf_pkg::REG_OPCODES:  opcode_table_r      <= pwdata[55:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      batf_pkg::REG_UID_LOW:  prdata = uid_low_r;
      batf_pkg::REG_UID_HIGH: prdata = {48'd0, uid_high_r};
      batf_pkg::REG_UID_LEN:  prdata = {60'd0, uid_length_r};
      batf_pkg::REG_MIN_HDR:  prdata = {60'd0, min_header_length_r};
      batf_pkg::REG_OPCODES:  prdata = {8'd0, opcode_table_r};
      default:                prdata = 64'd0;
    endcase
  end

  assign busy = q_full;
  assign push = start && !q_full;

  batf_front u_front (
    .in_cmd            (in_cmd),
    .in_p1             (in_p1),
    .in_p2             (in_p2),
    .in_len_byte       (in_len_byte),
    .in_data_bytes     (in_data_bytes),
    .in_apdu_length    (in_apdu_length),
    .in_out_capacity   (in_out_capacity),
    .uid_length        (uid_length_r),
    .min_header_length (min_header_length_r),
    .opcode_table      (opcode_table_r),
    .desc              (front_desc)
  );

  batf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (front_desc),
    .pop       (q_pop),
    .pop_desc  (q_desc),
    .full      (q_full),
    .empty     (q_empty)
  );

  batf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_desc         (q_desc),
    .q_pop          (q_pop),
    .uid            ({uid_high_r, uid_low_r}),
    .out_strobe     (out_strobe),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last),
    .out_status     (out_status)
  );

endmodule
